[rtl/core/rcf_pkg.sv]
// Shared types and constants for the RGB444 color fade core.
// No dependencies; imported by rcf_chan and rgb444_color_fade_core.
package rcf_pkg;

  localparam int CHAN_W  = 4;
  localparam int NUM_CH  = 3;
  localparam int COLOR_W = CHAN_W * NUM_CH;
  localparam int PROD_W  = 2 * CHAN_W;

  // floor(x / 15) == (x * 137) >> 11 for every x in 0..225
  localparam logic [PROD_W-1:0] RECIP15     = 8'd137;
  localparam int                RECIP_SHIFT = 11;
  localparam int                RECIP_W     = 2 * PROD_W;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 4'hf;

  typedef enum logic [1:0] {
    OP_TRANSITION = 2'd0,
    OP_INCREASE   = 2'd1,
    OP_DECREASE   = 2'd2
  } op_e;

  // Per-stage load enables driven by the top-level flow control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } rcf_adv_t;

endpackage

[rtl/core/rcf_chan.sv]
// Three-stage datapath for one 4-bit color channel: multiply, divide by 15, combine.
// Depends on rcf_pkg; stage enables come from rgb444_color_fade_core.
module rcf_chan (
  input  logic                          clk,
  input  rcf_pkg::rcf_adv_t             adv,
  input  rcf_pkg::op_e                  op,
  input  logic [rcf_pkg::CHAN_W-1:0]    from_ch,
  input  logic [rcf_pkg::CHAN_W-1:0]    to_ch,
  input  logic [rcf_pkg::CHAN_W-1:0]    step,
  output logic [rcf_pkg::CHAN_W-1:0]    result_ch
);
  import rcf_pkg::*;

  // stage 1: magnitude product
  op_e               op1_r;
  logic [CHAN_W-1:0] f1_r;
  logic              neg1_r;
  logic [PROD_W-1:0] prod1_r;
  // stage 2: quotient
  op_e               op2_r;
  logic [CHAN_W-1:0] f2_r;
  logic              neg2_r;
  logic [CHAN_W-1:0] q2_r;
  // stage 3: result
  logic [CHAN_W-1:0] res3_r;

  logic [CHAN_W-1:0]  mag_nxt;
  logic               neg_nxt;
  logic [PROD_W-1:0]  prod_nxt;
  logic [RECIP_W-1:0] recip_full;
  logic [CHAN_W-1:0]  q_nxt;
  logic [CHAN_W:0]    sum_w;
  logic [CHAN_W:0]    dif_w;
  logic [CHAN_W-1:0]  res_nxt;

  always_comb begin
    neg_nxt = 1'b0;
    mag_nxt = from_ch;
    unique case (op)
      OP_INCREASE, OP_DECREASE: begin
        neg_nxt = 1'b0;
        mag_nxt = from_ch;
      end
      default: begin
        // transition: work on |to - from| and restore the sign after the divide
        neg_nxt = (to_ch < from_ch);
        mag_nxt = neg_nxt ? (from_ch - to_ch) : (to_ch - from_ch);
      end
    endcase
    prod_nxt = PROD_W'(mag_nxt) * PROD_W'(step);
  end

  assign recip_full = RECIP_W'(prod1_r) * RECIP_W'(RECIP15);
  assign q_nxt      = recip_full[RECIP_SHIFT +: CHAN_W];

  assign sum_w = {1'b0, f2_r} + {1'b0, q2_r};
  assign dif_w = {1'b0, f2_r} - {1'b0, q2_r};

  always_comb begin
    unique case (op2_r)
      OP_INCREASE: res_nxt = sum_w[CHAN_W] ? CHAN_MAX : sum_w[CHAN_W-1:0];
      OP_DECREASE: res_nxt = dif_w[CHAN_W] ? '0 : dif_w[CHAN_W-1:0];
      default:     res_nxt = neg2_r ? dif_w[CHAN_W-1:0] : sum_w[CHAN_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      op1_r   <= op;
      f1_r    <= from_ch;
      neg1_r  <= neg_nxt;
      prod1_r <= prod_nxt;
    end
    if (adv.s2) begin
      op2_r  <= op1_r;
      f2_r   <= f1_r;
      neg2_r <= neg1_r;
      q2_r   <= q_nxt;
    end
    if (adv.s3) begin
      res3_r <= res_nxt;
    end
  end

  assign result_ch = res3_r;

endmodule

[rtl/core/rgb444_color_fade_core.sv]
// RGB444 color fade core: transition, increase and decrease contrast per channel.
// Stages from input transfer to output transfer: multiply, divide (by reciprocal), combine.
// Throughput: one color per cycle while out_tready stays high.
// Each stage holds independently under backpressure, so bubbles are squeezed out.
// Reset (rst_n low, synchronous) empties the pipeline; payload registers are not reset.
// Depends on rcf_pkg and rcf_chan.
module rgb444_color_fade_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // from_color[11:0], to_color[23:12], step[27:24], zero[31:28]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // result_color[11:0], zero[15:12]
);
  import rcf_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  rcf_adv_t adv;

  logic [COLOR_W-1:0] from_color;
  logic [COLOR_W-1:0] to_color;
  logic [CHAN_W-1:0]  step;
  op_e                op;
  logic [COLOR_W-1:0] result_color;

  assign from_color = in_tdata[COLOR_W-1:0];
  assign to_color   = in_tdata[2*COLOR_W-1:COLOR_W];
  assign step       = in_tdata[2*COLOR_W +: CHAN_W];
  assign op         = op_e'(in_tuser);

  // a stage advances when it is empty or the next stage advances
  always_comb begin
    adv.s3 = !v3_r || out_tready;
    adv.s2 = !v2_r || adv.s3;
    adv.s1 = !v1_r || adv.s2;
  end

  assign in_tready = adv.s1;

  always_comb begin
    v1_nxt = adv.s1 ? in_tvalid : v1_r;
    v2_nxt = adv.s2 ? v1_r      : v2_r;
    v3_nxt = adv.s3 ? v2_r      : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_chan
    rcf_chan u_chan (
      .clk       (clk),
      .adv       (adv),
      .op        (op),
      .from_ch   (from_color[k*CHAN_W +: CHAN_W]),
      .to_ch     (to_color[k*CHAN_W +: CHAN_W]),
      .step      (step),
      .result_ch (result_color[k*CHAN_W +: CHAN_W])
    );
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {4'b0, result_color};

  // an accepted transfer always lands in stage 1
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted transfer did not reach stage 1");

  // a blocked stage 1 keeps its item
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !adv.s2 |=> v1_r)
    else $error("stage 1 item dropped while blocked");

  // with output stalled, stage 2 and 3 items both stay
  a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && v2_r && !out_tready |=> v2_r && v3_r)
    else $error("item lost under output stall");

  // stage 1 can only be refilled from the input when stage 2 takes its item
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && in_tready |-> adv.s2)
    else $error("stage 1 overwritten while full");

endmodule
